[sv/lapsh_pkg.sv]
// lapsh_pkg: shared types and constants of the 3x3 cross sharpen filter.
// No dependencies; every other file of the block imports it.
package lapsh_pkg;

  localparam int SMP_W      = 8;
  localparam int CFG_W_W    = 12;
  localparam int CFG_H_W    = 13;
  localparam int CFG_C_W    = 3;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_W      = 13;

  // Decoupling queue between the front and the back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [CFG_W_W-1:0] RST_IMG_WIDTH     = 12'd640;
  localparam logic [CFG_H_W-1:0] RST_IMG_HEIGHT    = 13'd480;
  localparam logic [CFG_C_W-1:0] RST_CHANNEL_COUNT = 3'd3;

  // Item kinds
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_FLUSH  = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [SMP_W-1:0] sample;
  } lapsh_in_t;

  typedef struct packed {
    logic [SMP_W-1:0] value;
    logic             frame_end;
  } lapsh_out_t;

  // Operands of one result, as classified by the front
  typedef struct packed {
    logic             interior;
    logic             frame_end;
    logic [SMP_W-1:0] centre;
    logic [SMP_W-1:0] left;
    logic [SMP_W-1:0] right;
    logic [SMP_W-1:0] up;
    logic [SMP_W-1:0] down;
  } lapsh_op_t;

  // One queue slot plus its valid flag (front to queue, queue head to back)
  typedef struct packed {
    logic      vld;
    lapsh_op_t op;
  } lapsh_xfer_t;

endpackage

[sv/laplacian_sharpen_3x3_unit.sv]
// laplacian_sharpen_3x3_unit: top level of the streaming 3x3 cross sharpen filter.
// Uses lapsh_pkg, lapsh_front, lapsh_queue and lapsh_back.
//
//   channel | ports                            | item
//   --------+----------------------------------+-------------------------------
//   in      | in_valid, in_stall, in_data      | mode + one channel byte
//   out     | out_valid, out_stall, out_data   | sharpened byte + frame_end
//   cfg     | cfg_we, cfg_index, cfg_data      | img_width/img_height/channels
//
// Flow: one item per clock sustained while out_stall stays low; a result reaches
// out_data through the line store read at the edge that accepts its item, then
// the queue, then the output register.
// Reset: synchronous, active low; counters, window and config return to their
// defaults at once. The line stores are not cleared and need no sweep.
// Stalls: in_stall is raised when the four-entry queue has no room for the items
// already in flight; out_stall holds the output register and fills the queue.
module laplacian_sharpen_3x3_unit #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_HEIGHT   = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [lapsh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lapsh_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lapsh_pkg::lapsh_in_t              in_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output lapsh_pkg::lapsh_out_t             out_data
);
  import lapsh_pkg::*;

  lapsh_xfer_t     push;   // front -> queue
  lapsh_xfer_t     head;   // queue -> back
  logic            pop;
  logic [Q_CW-1:0] level;
  logic [Q_CW:0]   need;
  logic            in_acc;

  // Room check counts the item sitting in the front's read stage, which
  // lands in the queue at the next edge.
  assign need     = {1'b0, level} + {{Q_CW{1'b0}}, push.vld};
  assign in_stall = (need >= (Q_CW + 1)'(Q_DEPTH));
  assign in_acc   = in_valid && !in_stall;

  // Front: geometry, counters, classification, line stores
  lapsh_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_HEIGHT  (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_acc   (in_acc),
    .in_data  (in_data),
    .push     (push)
  );

  // Queue decouples the front from output back-pressure
  lapsh_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .head (head),
    .level(level)
  );

  // Back: arithmetic, clamp and the output register
  lapsh_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

[sv/lapsh_front.sv]
// lapsh_front: config registers, row/column counters, item classification,
// the two line stores and the left-neighbour window. Uses lapsh_pkg.
module lapsh_front #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_HEIGHT   = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lapsh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lapsh_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               in_acc,
  input  lapsh_pkg::lapsh_in_t               in_data,
  output lapsh_pkg::lapsh_xfer_t             push
);
  import lapsh_pkg::*;

  localparam int SD  = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW  = $clog2(SD);
  localparam int LW  = $clog2(SD + 1);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int WXW = (WW > CFG_W_W) ? WW : CFG_W_W;
  localparam int CW  = $clog2(MAX_CHANNELS + 1);
  localparam int CXW = (CW > CFG_C_W) ? CW : CFG_C_W;
  localparam int HXW = ROW_W + 1;
  localparam int WD  = MAX_CHANNELS;
  localparam int WIW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [CFG_W_W-1:0] img_width_r;
  logic [CFG_H_W-1:0] img_height_r;
  logic [CFG_C_W-1:0] chan_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= RST_IMG_WIDTH;
      img_height_r <= RST_IMG_HEIGHT;
      chan_cnt_r   <= RST_CHANNEL_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMG_WIDTH:     img_width_r  <= cfg_data[CFG_W_W-1:0];
        REG_IMG_HEIGHT:    img_height_r <= cfg_data[CFG_H_W-1:0];
        REG_CHANNEL_COUNT: chan_cnt_r   <= cfg_data[CFG_C_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry
  logic [WXW-1:0]     w_ext;
  logic [WW-1:0]      w_eff;
  logic [CXW-1:0]     c_ext;
  logic [CW-1:0]      c_eff;
  logic [CW-1:0]      c_m1;
  logic [HXW-1:0]     h_ext;
  logic [HXW-1:0]     h_eff;
  logic [WW+CW-1:0]   prod;
  logic [LW-1:0]      len;

  always_comb begin
    w_ext = WXW'(img_width_r);
    if (w_ext < WXW'(3))               w_eff = WW'(3);
    else if (w_ext > WXW'(MAX_WIDTH))  w_eff = WW'(MAX_WIDTH);
    else                               w_eff = w_ext[WW-1:0];
    c_ext = CXW'(chan_cnt_r);
    if (c_ext < CXW'(1))                  c_eff = CW'(1);
    else if (c_ext > CXW'(MAX_CHANNELS))  c_eff = CW'(MAX_CHANNELS);
    else                                  c_eff = c_ext[CW-1:0];
    h_ext = HXW'(img_height_r);
    if (h_ext < HXW'(3))               h_eff = HXW'(3);
    else if (h_ext > HXW'(MAX_HEIGHT)) h_eff = HXW'(MAX_HEIGHT);
    else                               h_eff = h_ext;
    prod = {{CW{1'b0}}, w_eff} * {{WW{1'b0}}, c_eff};
    len  = prod[LW-1:0];
    c_m1 = c_eff - 1'b1;
  end

  // Counters and classification
  logic [AW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [LW:0]      col_ext, b_inc, b_pc, len_ext;
  logic [AW-1:0]    right_addr;
  logic             flush_phase, last_b, interior;

  logic             s1_emit_r, s1_emit_nxt;
  logic             s1_wr_r,   s1_wr_nxt;
  logic             s1_clr_r,  s1_clr_nxt;
  logic             s1_int_r,  s1_int_nxt;
  logic             s1_fe_r,   s1_fe_nxt;
  logic [AW-1:0]    s1_addr_r;
  logic [SMP_W-1:0] s1_sample_r;

  always_comb begin
    col_ext     = {{(LW + 1 - AW){1'b0}}, col_r};
    len_ext     = {1'b0, len};
    b_inc       = col_ext + 1'b1;
    b_pc        = col_ext + {{(LW + 1 - CW){1'b0}}, c_eff};
    right_addr  = b_pc[AW-1:0];
    last_b      = (b_inc >= len_ext);
    flush_phase = ({1'b0, row_r} >= h_eff);
    interior    = (row_r >= ROW_W'(2)) &&
                  (col_ext >= {{(LW + 1 - CW){1'b0}}, c_eff}) && (b_pc < len_ext);

    col_nxt     = col_r;
    row_nxt     = row_r;
    s1_emit_nxt = 1'b0;
    s1_wr_nxt   = 1'b0;
    s1_clr_nxt  = 1'b0;
    s1_int_nxt  = 1'b0;
    s1_fe_nxt   = 1'b0;
    if (in_acc) begin
      if (flush_phase) begin
        // last row goes out as border, one flush item per byte
        if (in_data.mode == MODE_FLUSH) begin
          s1_emit_nxt = 1'b1;
          s1_fe_nxt   = last_b;
          if (last_b) begin
            col_nxt    = '0;
            row_nxt    = '0;
            s1_clr_nxt = 1'b1;
          end else begin
            col_nxt = b_inc[AW-1:0];
          end
        end
      end else if (in_data.mode == MODE_SAMPLE) begin
        s1_wr_nxt   = 1'b1;
        s1_emit_nxt = (row_r != '0);
        s1_int_nxt  = interior;
        if (last_b) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = b_inc[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      s1_emit_r <= 1'b0;
      s1_wr_r   <= 1'b0;
      s1_clr_r  <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      s1_emit_r <= s1_emit_nxt;
      s1_wr_r   <= s1_wr_nxt;
      s1_clr_r  <= s1_clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_int_r    <= s1_int_nxt;
    s1_fe_r     <= s1_fe_nxt;
    s1_addr_r   <= col_r;
    s1_sample_r <= in_data.sample;
  end

  // Line stores: read on accept, written in the following cycle by the same item.
  // Any address an item reads was last written at least two items earlier.
  logic [SMP_W-1:0] line_cur_r  [SD];
  logic [SMP_W-1:0] line_prev_r [SD];
  logic [SMP_W-1:0] cur_a_r, cur_b_r, prev_a_r;

  always_ff @(posedge clk) begin
    if (s1_wr_nxt) begin
      cur_a_r <= line_cur_r[col_r];
      cur_b_r <= line_cur_r[right_addr];
    end
    if (s1_wr_r) begin
      line_cur_r[s1_addr_r] <= s1_sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr_nxt) begin
      prev_a_r <= line_prev_r[col_r];
    end
    if (s1_wr_r) begin
      line_prev_r[s1_addr_r] <= cur_a_r;
    end
  end

  // Held-row bytes already replaced; entry c-1 is the left neighbour
  logic [SMP_W-1:0] win_r [WD];

  always_ff @(posedge clk) begin
    if (!rst_n || s1_clr_r) begin
      for (int k = 0; k < WD; k++) win_r[k] <= '0;
    end else if (s1_wr_r) begin
      for (int k = WD - 1; k > 0; k--) win_r[k] <= win_r[k-1];
      win_r[0] <= cur_a_r;
    end
  end

  always_comb begin
    push.vld          = s1_emit_r;
    push.op.interior  = s1_int_r;
    push.op.frame_end = s1_fe_r;
    push.op.centre    = cur_a_r;
    push.op.left      = win_r[c_m1[WIW-1:0]];
    push.op.right     = cur_b_r;
    push.op.up        = prev_a_r;
    push.op.down      = s1_sample_r;
  end

endmodule

[sv/lapsh_queue.sv]
// lapsh_queue: short FIFO of classified operands between front and back.
// Uses lapsh_pkg; the writer never pushes into a full queue.
module lapsh_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lapsh_pkg::lapsh_xfer_t        push,
  input  logic                          pop,
  output lapsh_pkg::lapsh_xfer_t        head,
  output logic [lapsh_pkg::Q_CW-1:0]    level
);
  import lapsh_pkg::*;

  lapsh_op_t        slots_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push.vld ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {{(Q_CW-1){1'b0}}, push.vld} - {{(Q_CW-1){1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) slots_r[wr_ptr_r] <= push.op;
  end

  assign head.vld = (cnt_r != '0);
  assign head.op  = slots_r[rd_ptr_r];
  assign level    = cnt_r;

endmodule

[sv/lapsh_back.sv]
// lapsh_back: 5*centre minus four neighbours, clamp (0 at borders), output register.
// Uses lapsh_pkg; pops the queue head whenever the output slot frees.
module lapsh_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lapsh_pkg::lapsh_xfer_t   head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output lapsh_pkg::lapsh_out_t    out_data
);
  import lapsh_pkg::*;

  logic [10:0]      pos, neg, diff;
  logic [SMP_W-1:0] val;
  logic             load;
  logic             out_vld_r;
  lapsh_out_t       out_r;

  always_comb begin
    pos  = {1'b0, head.op.centre, 2'b00} + {3'b000, head.op.centre};
    neg  = {3'b000, head.op.left} + {3'b000, head.op.right} +
           {3'b000, head.op.up} + {3'b000, head.op.down};
    diff = pos - neg;
    if (!head.op.interior || (pos < neg)) val = '0;
    else if (diff > 11'd255)              val = 8'd255;
    else                                  val = diff[SMP_W-1:0];
  end

  assign load = !out_vld_r || !out_stall;
  assign pop  = head.vld && load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= head.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r.value     <= val;
      out_r.frame_end <= head.op.frame_end;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for laplacian_sharpen_3x3_unit (3x3 cross sharpen filter).
// Drives directed and random frames, predicts every result and compares it in order.
// Depends on lapsh_pkg and the RTL of the block only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lapsh_pkg::*;

  localparam int MAX_W  = 2048;
  localparam int MAX_CH = 4;
  localparam int MAX_H  = 4096;
  localparam int STORE_DEPTH  = 8192;
  localparam int WIN_DEPTH    = 9;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_AT      = 150;     // accepted items before the long receiver hold
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 8;      // margin beyond read stage, queue and output register
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TIMEOUT_NS   = 100_000_000;

  // one queued input item plus the idle cycles the sender spends before it
  typedef struct {
    lapsh_in_t   item;
    int unsigned gap;
  } feed_entry_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  lapsh_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  lapsh_out_t out_data;

  laplacian_sharpen_3x3_unit #(
    .MAX_WIDTH    (MAX_W),
    .MAX_CHANNELS (MAX_CH),
    .MAX_HEIGHT   (MAX_H)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Filter predictor: own copy of registers, line stores, counters and window.
  // ---------------------------------------------------------------------------
  logic [CFG_W_W-1:0] wid_reg  = RST_IMG_WIDTH;
  logic [CFG_H_W-1:0] hgt_reg  = RST_IMG_HEIGHT;
  logic [CFG_C_W-1:0] chan_reg = RST_CHANNEL_COUNT;

  logic [SMP_W-1:0] held_row  [0:STORE_DEPTH-1];   // row whose results are due next
  logic [SMP_W-1:0] older_row [0:STORE_DEPTH-1];   // the row above it
  logic [SMP_W-1:0] left_win  [0:WIN_DEPTH-1];     // recent held-row bytes, newest first
  logic [ROW_W-1:0] col_pos = '0;
  logic [ROW_W-1:0] rows_in = '0;

  function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                              int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the predictor by one accepted item; returns 1 when a result is due.
  function automatic bit sharpen_item(input lapsh_in_t it, output lapsh_out_t res);
    int unsigned w, h, c, len, b, r;
    int acc;
    logic [SMP_W-1:0] centre, left;
    bit got;
    w = clamp_range(32'(wid_reg), 3, MAX_W);
    h = clamp_range(32'(hgt_reg), 3, MAX_H);
    c = clamp_range(32'(chan_reg), 1, MAX_CH);
    len = w * c;
    b = 32'(col_pos);
    res = '0;
    got = 1'b0;

    // all rows in: only flush items count, each one emits a border byte of the last row
    if (rows_in >= h) begin
      if (it.mode == MODE_SAMPLE) return 1'b0;
      res.frame_end = (b + 1 >= len);
      if (b + 1 >= len) begin
        col_pos = '0;
        rows_in = '0;
        for (int k = 0; k < WIN_DEPTH; k++) left_win[k] = '0;
      end else begin
        col_pos = ROW_W'(b + 1);
      end
      return 1'b1;
    end

    // flush before the frame is complete is dropped
    if (it.mode == MODE_FLUSH) return 1'b0;

    centre = held_row[b];
    left   = left_win[c-1];
    // the first row only fills the store; later rows release the row above
    if (rows_in >= 1) begin
      r = rows_in - 1;
      if (r >= 1 && r + 1 < h && b >= c && b + c < len) begin
        acc = 5 * int'(centre) - int'(left) - int'(held_row[b+c])
              - int'(older_row[b]) - int'(it.sample);
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        res.value = acc[SMP_W-1:0];
      end
      got = 1'b1;
    end

    for (int k = WIN_DEPTH - 1; k > 0; k--) left_win[k] = left_win[k-1];
    left_win[0]  = centre;
    older_row[b] = centre;
    held_row[b]  = it.sample;

    if (b + 1 >= len) begin
      col_pos = '0;
      rows_in = rows_in + 1'b1;
    end else begin
      col_pos = ROW_W'(b + 1);
    end
    return got;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues, counters and shared helpers
  // ---------------------------------------------------------------------------
  feed_entry_t byte_feed_q[$];     // items still to be offered
  lapsh_out_t  owed_bytes_q[$];    // sharpened bytes predicted, not yet seen
  int unsigned bytes_taken = 0;    // input items accepted so far
  int unsigned err_count = 0;
  logic        in_taken = 1'b0;    // item on in_data was accepted at the last edge

  task automatic note_fail(string msg);
    err_count++;
    if (err_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // mostly short gaps, some medium, a few long
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // bytes lean to 0 and 255 so both clamps are hit often
  function automatic logic [SMP_W-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) return '0;
    if (r < 24) return '1;
    return SMP_W'($urandom_range(255));
  endfunction

  function automatic void push_item(logic mode, logic [SMP_W-1:0] smp, bit calm);
    feed_entry_t e;
    e.item.mode   = mode;
    e.item.sample = smp;
    e.gap = pick_gap(calm);
    byte_feed_q.push_back(e);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: new item at the falling edge, held until accepted
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
      // stalled: keep item and valid as they are
    end else if (byte_feed_q.size() == 0) begin
      in_valid <= 1'b0;
    end else if (byte_feed_q[0].gap != 0) begin
      byte_feed_q[0].gap = byte_feed_q[0].gap - 1;
      in_valid <= 1'b0;
    end else begin
      in_data  <= byte_feed_q[0].item;
      in_valid <= 1'b1;
      void'(byte_feed_q.pop_front());
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: quiet and busy stretches, plus one long hold so the block
  // backs up into in_stall while the sender keeps offering.
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned mode_left = 0;
  bit          quiet = 1'b1;
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    if (!hold_done && bytes_taken >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        quiet     = ($urandom_range(2) == 0);
        mode_left = $urandom_range(200, 20);
      end
      mode_left--;
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap(1'b0);
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge, check the result handshake first, then feed
  // the accepted input item to the predictor.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : edge_check
    lapsh_out_t owed;
    lapsh_out_t res;
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (owed_bytes_q.size() == 0) begin
          note_fail($sformatf("unexpected result value=%0d frame_end=%0b",
                              out_data.value, out_data.frame_end));
        end else begin
          owed = owed_bytes_q.pop_front();
          if (owed.value != out_data.value || owed.frame_end != out_data.frame_end)
            note_fail($sformatf("value exp %0d got %0d, frame_end exp %0b got %0b",
                                owed.value, out_data.value,
                                owed.frame_end, out_data.frame_end));
        end
      end
      if (in_valid && !in_stall) begin
        bytes_taken++;
        if (sharpen_item(in_data, res)) owed_bytes_q.push_back(res);
      end
    end else begin
      in_taken <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_IMG_WIDTH:     wid_reg  = val[CFG_W_W-1:0];
      REG_IMG_HEIGHT:    hgt_reg  = val[CFG_H_W-1:0];
      REG_CHANNEL_COUNT: chan_reg = val[CFG_C_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for the sender to empty and every owed result to show up. Leftovers
  // after the drain limit are failures and are dropped so the run goes on.
  task automatic settle();
    int unsigned waited;
    waited = 0;
    while (byte_feed_q.size() != 0 || in_valid) @(posedge clk);
    while (owed_bytes_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_bytes_q.size() != 0) begin
      note_fail($sformatf("%0d predicted results never arrived", owed_bytes_q.size()));
      owed_bytes_q.delete();
    end
  endtask

  // One whole frame at the current geometry: rows of samples, then one flush
  // per byte of the last row. Noise adds early flushes and late samples, both
  // of which the block drops. n returns the items that matter.
  task automatic queue_frame(bit noisy, bit calm, output int unsigned n);
    int unsigned w, h, c, len;
    w = clamp_range(32'(wid_reg), 3, MAX_W);
    h = clamp_range(32'(hgt_reg), 3, MAX_H);
    c = clamp_range(32'(chan_reg), 1, MAX_CH);
    len = w * c;
    for (int r = 0; r < h; r++) begin
      for (int b = 0; b < len; b++) begin
        if (noisy && $urandom_range(99) < 4) push_item(MODE_FLUSH, pick_byte(), calm);
        push_item(MODE_SAMPLE, pick_byte(), calm);
      end
    end
    for (int b = 0; b < len; b++) begin
      if (noisy && $urandom_range(99) < 8) push_item(MODE_SAMPLE, pick_byte(), calm);
      push_item(MODE_FLUSH, pick_byte(), calm);
    end
    n = len * (h + 1);
  endtask

  initial begin : run_seq
    int unsigned n, rand_bytes, frame_no;
    logic [CFG_DATA_W-1:0] wv, hv, cv;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      held_row[i]  = '0;
      older_row[i] = '0;
    end
    for (int k = 0; k < WIN_DEPTH; k++) left_win[k] = '0;

    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Smallest geometry, reached through values below the range (all clamp to
    // 3 x 3 pixels, one channel).
    write_reg(REG_IMG_WIDTH, '0);
    write_reg(REG_IMG_HEIGHT, 13'd2);
    write_reg(REG_CHANNEL_COUNT, '0);

    // Frame 1: lone bright centre saturates high. A flush in mid-frame and a
    // sample after the last row are both dropped.
    push_item(MODE_SAMPLE, 8'd0, 1'b0);
    push_item(MODE_SAMPLE, 8'd0, 1'b0);
    push_item(MODE_SAMPLE, 8'd0, 1'b0);
    push_item(MODE_SAMPLE, 8'd0, 1'b0);
    push_item(MODE_FLUSH, 8'd255, 1'b0);
    push_item(MODE_SAMPLE, 8'd255, 1'b0);
    push_item(MODE_SAMPLE, 8'd0, 1'b0);
    push_item(MODE_SAMPLE, 8'd0, 1'b0);
    push_item(MODE_SAMPLE, 8'd0, 1'b0);
    push_item(MODE_SAMPLE, 8'd0, 1'b0);
    push_item(MODE_SAMPLE, 8'd170, 1'b0);
    push_item(MODE_FLUSH, 8'd0, 1'b0);
    push_item(MODE_FLUSH, 8'd255, 1'b0);
    push_item(MODE_FLUSH, 8'd0, 1'b0);
    // Frame 2, straight after the frame end: dark centre in bright ring clamps to 0.
    push_item(MODE_SAMPLE, 8'd255, 1'b0);
    push_item(MODE_SAMPLE, 8'd255, 1'b0);
    push_item(MODE_SAMPLE, 8'd255, 1'b0);
    push_item(MODE_SAMPLE, 8'd255, 1'b0);
    push_item(MODE_SAMPLE, 8'd0, 1'b0);
    push_item(MODE_SAMPLE, 8'd255, 1'b0);
    push_item(MODE_SAMPLE, 8'd255, 1'b0);
    push_item(MODE_SAMPLE, 8'd255, 1'b0);
    push_item(MODE_SAMPLE, 8'd255, 1'b0);
    push_item(MODE_FLUSH, 8'd0, 1'b0);
    push_item(MODE_FLUSH, 8'd0, 1'b0);
    push_item(MODE_FLUSH, 8'd0, 1'b0);
    settle();

    // Random frames with small geometry; registers change only between frames
    // after a full drain. Frames with unchanged geometry run back to back.
    rand_bytes = 0;
    frame_no = 0;
    while (rand_bytes < RANDOM_ITEMS) begin
      if (frame_no == 0 || $urandom_range(3) != 0) begin
        wv = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(2))
                                      : CFG_DATA_W'($urandom_range(8, 3));
        hv = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(2))
                                      : CFG_DATA_W'($urandom_range(6, 3));
        case ($urandom_range(9))
          0:       cv = '0;
          1:       cv = CFG_DATA_W'($urandom_range(7, 5));
          default: cv = CFG_DATA_W'($urandom_range(4, 1));
        endcase
        if (frame_no == 0) cv = 13'd7;   // above range, clamps to four channels
        settle();
        write_reg(REG_IMG_WIDTH, wv);
        write_reg(REG_IMG_HEIGHT, hv);
        write_reg(REG_CHANNEL_COUNT, cv);
      end
      // stray flushes between frames are dropped
      if ($urandom_range(4) == 0) push_item(MODE_FLUSH, pick_byte(), 1'b0);
      queue_frame($urandom_range(3) != 0, $urandom_range(3) == 0, n);
      rand_bytes += n;
      frame_no++;
    end
    settle();

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
sv/lapsh_pkg.sv
sv/lapsh_front.sv
sv/lapsh_queue.sv
sv/lapsh_back.sv
sv/laplacian_sharpen_3x3_unit.sv
tb/tb_top.sv
